// File: hdl/bdel_pkg.sv
// shared types and constants for the bounded double-ended list
// opcodes, status codes and the result metadata struct; no dependencies
`default_nettype none
package bdel_pkg;

	localparam int DEF_CAPACITY = 256;
	localparam int ELEM_W       = 32;
	localparam int POS_W        = 8;
	localparam int OP_W         = 3;
	localparam int CNT_OUT_W    = 9;
	localparam int IN_TDATA_W   = 48;
	localparam int OUT_TDATA_W  = 48;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_READ_FRONT = 3'd4,
		OP_READ_BACK  = 3'd5,
		OP_READ_INDEX = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} st_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] entry_count;
		st_t                  status;
		logic                 read_valid;
	} meta_t;

endpackage
`default_nettype wire

// File: hdl/bdel_ram.sv
// generic single-address ram with registered read data
// no dependencies
`default_nettype none
module bdel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/bdel_ctrl.sv
// front pointer and occupancy registers, slot arithmetic and operation decode
// depends on bdel_pkg; drives the record ram request and result metadata
`default_nettype none
module bdel_ctrl import bdel_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [OP_W-1:0]   opcode,
	input  wire logic [ELEM_W-1:0] element,
	input  wire logic [POS_W-1:0]  position,
	output logic                   ram_we,
	output logic                   ram_re,
	output logic      [AW-1:0]     ram_addr,
	output logic      [ELEM_W-1:0] ram_wdata,
	output meta_t                  meta
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int MW0   = (AW > POS_W) ? AW : POS_W;
	localparam int MW1   = (MW0 > CNT_W) ? MW0 : CNT_W;
	localparam int SW    = MW1 + 1;
	localparam int EW    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

	logic [AW-1:0]    front_q, front_d, front_inc, front_dec, slot;
	logic [CNT_W-1:0] count_q, count_d;
	logic [SW-1:0]    offset, sum;
	logic [EW-1:0]    count_ext;
	logic             full, empty, in_range, we, re;
	st_t              status;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign in_range  = (SW'(position) < SW'(count_q));
	assign front_inc = (front_q == AW'(CAPACITY - 1)) ? '0 : front_q + AW'(1);
	assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - AW'(1);

	// front plus offset stays below twice the capacity whenever the slot is used
	assign sum  = SW'(front_q) + offset;
	assign slot = (sum >= SW'(CAPACITY)) ? AW'(sum - SW'(CAPACITY)) : AW'(sum);

	always_comb begin
		front_d    = front_q;
		count_d    = count_q;
		offset     = '0;
		we         = 1'b0;
		re         = 1'b0;
		status     = ST_DONE;
		ram_addr   = slot;
		unique case (opcode)
			OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					front_d  = front_dec;
					count_d  = count_q + CNT_W'(1);
					ram_addr = front_dec;
					we       = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				offset = SW'(count_q);
				if (full) begin
					status = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					we      = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					front_d = front_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_READ_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					re = 1'b1;
				end
			end
			OP_READ_BACK: begin
				offset = SW'(count_q - CNT_W'(1));
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					re = 1'b1;
				end
			end
			OP_READ_INDEX: begin
				offset = SW'(position);
				if (!in_range) begin
					status = ST_RANGE;
				end else begin
					re = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_we    = accept & we;
	assign ram_re    = accept & re;
	assign ram_wdata = element;

	assign count_ext        = EW'(count_d);
	assign meta.entry_count = count_ext[CNT_OUT_W-1:0];
	assign meta.status      = status;
	assign meta.read_valid  = re;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("occupancy beyond capacity");

	a_full_push_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK)
		|=> $stable(count_q) && $stable(front_q))
		else $error("push to a full list changed the list");

	a_pop_back: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !empty && opcode == OP_POP_BACK
		|=> count_q == $past(count_q) - CNT_W'(1) && $stable(front_q))
		else $error("pop back did not drop exactly one record");
`endif

endmodule
`default_nettype wire

// File: hdl/bounded_double_ended_list.sv
// Bounded double-ended list of 32-bit records held in a circular buffer: one
// operation per beat, sustained at one beat per clock unless both result
// stages are full and m_tready is low. The read data is registered in the
// record ram and again in the output register; each operation makes at most
// one ram access, done in the cycle the beat is taken, so a read sees every
// earlier write. The record store needs no clearing pass after reset.
// depends on bdel_pkg, bdel_ctrl and bdel_ram
`default_nettype none
module bounded_double_ended_list import bdel_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// opcode[2:0], element[34:3], position[42:35], zero fill
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// read_data[31:0], read_valid[32], status[34:33], entry_count[43:35], zero fill
	output logic      [OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic              accept, move_s1;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_addr;
	logic [ELEM_W-1:0] ram_wdata, ram_rdata;
	meta_t             meta;
	logic              valid_s1, valid_s2;
	meta_t             meta_s1, meta_s2;
	logic [ELEM_W-1:0] data_s2;

	assign s_tready = !valid_s1 || !valid_s2 || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign move_s1  = valid_s1 && (!valid_s2 || m_tready);

	bdel_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (s_tdata[OP_W-1:0]),
		.element  (s_tdata[OP_W+ELEM_W-1:OP_W]),
		.position (s_tdata[OP_W+ELEM_W+POS_W-1:OP_W+ELEM_W]),
		.ram_we   (ram_we),
		.ram_re   (ram_re),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata),
		.meta     (meta)
	);

	bdel_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
		if (move_s1) begin
			meta_s2 <= meta_s1;
			data_s2 <= meta_s1.read_valid ? ram_rdata : '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OUT_TDATA_W - ELEM_W - CNT_OUT_W - 3)'(0), meta_s2.entry_count,
		meta_s2.status, meta_s2.read_valid, data_s2};

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move_s1 |=> valid_s1 && $stable(meta_s1))
		else $error("waiting result lost its metadata");

	a_valid_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && meta_s2.read_valid |-> meta_s2.status == ST_DONE)
		else $error("valid read with a failure status");
`endif

endmodule
`default_nettype wire

// File: tb/tb_bounded_double_ended_list.sv
// testbench for bounded_double_ended_list: directed and random deque operations
// checked beat by beat against a scoreboard that tracks the list contents
// depends on bdel_pkg and bounded_double_ended_list
`default_nettype none
module tb_bounded_double_ended_list;
	import bdel_pkg::*;

	localparam int DEPTH          = DEF_CAPACITY;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic [ELEM_W-1:0]    data;
		logic                 valid;
		st_t                  status;
		logic [CNT_OUT_W-1:0] count;
	} outcome_t;

	class deque_scoreboard;
		logic [ELEM_W-1:0] records [DEPTH];
		int unsigned       head;
		int unsigned       held;
		outcome_t          awaited [$];
		int                errors;

		function new();
			head   = 0;
			held   = 0;
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_op(logic [IN_TDATA_W-1:0] beat);
			logic [OP_W-1:0]   op;
			logic [ELEM_W-1:0] elem;
			int unsigned       pos;
			outcome_t          res;
			op   = beat[OP_W-1:0];
			elem = beat[OP_W +: ELEM_W];
			pos  = beat[OP_W+ELEM_W +: POS_W];
			res  = '0;
			res.status = ST_DONE;
			case (op)
				OP_PUSH_FRONT: begin
					if (held >= DEPTH) begin
						res.status = ST_FULL;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						records[head] = elem;
						held++;
					end
				end
				OP_PUSH_BACK: begin
					if (held >= DEPTH) begin
						res.status = ST_FULL;
					end else begin
						records[(head + held) % DEPTH] = elem;
						held++;
					end
				end
				OP_POP_FRONT: begin
					if (held == 0) begin
						res.status = ST_EMPTY;
					end else begin
						head = (head + 1) % DEPTH;
						held--;
					end
				end
				OP_POP_BACK: begin
					if (held == 0) res.status = ST_EMPTY;
					else held--;
				end
				OP_READ_FRONT: begin
					if (held == 0) begin
						res.status = ST_EMPTY;
					end else begin
						res.data  = records[head];
						res.valid = 1'b1;
					end
				end
				OP_READ_BACK: begin
					if (held == 0) begin
						res.status = ST_EMPTY;
					end else begin
						res.data  = records[(head + held - 1) % DEPTH];
						res.valid = 1'b1;
					end
				end
				OP_READ_INDEX: begin
					if (pos >= held) begin
						res.status = ST_RANGE;
					end else begin
						res.data  = records[(head + pos) % DEPTH];
						res.valid = 1'b1;
					end
				end
				default: begin
				end
			endcase
			res.count = CNT_OUT_W'(held);
			awaited.push_back(res);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] beat);
			outcome_t want;
			if (awaited.size() == 0) begin
				$error("result beat %h with no operation outstanding", beat);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (beat[31:0] !== want.data) begin
				$error("read_data expected %h actual %h", want.data, beat[31:0]);
				errors++;
			end
			if (beat[32] !== want.valid) begin
				$error("read_valid expected %0d actual %0d", want.valid, beat[32]);
				errors++;
			end
			if (beat[34:33] !== want.status) begin
				$error("status expected %0d actual %0d", want.status, beat[34:33]);
				errors++;
			end
			if (beat[43:35] !== want.count) begin
				$error("entry_count expected %0d actual %0d", want.count, beat[43:35]);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	logic in_taken;
	logic hold_req;
	int   hold_left;
	int   quiet;
	int   tx_idle_pct;
	int   rx_idle_pct;

	deque_scoreboard sb;

	bounded_double_ended_list uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) sb.note_op(s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("tb_bounded_double_ended_list: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			m_tready  <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_req  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	function automatic logic [IN_TDATA_W-1:0] pack_op(logic [OP_W-1:0] op,
		logic [ELEM_W-1:0] elem, logic [POS_W-1:0] pos);
		logic [IN_TDATA_W-1:0] beat;
		beat = '0;
		beat[OP_W-1:0]              = op;
		beat[OP_W +: ELEM_W]        = elem;
		beat[OP_W+ELEM_W +: POS_W]  = pos;
		return beat;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] random_op(int push_pct, int pop_pct);
		int              r;
		int unsigned     held;
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;
		held = sb.held;
		r    = $urandom_range(0, 99);
		if (r < push_pct) begin
			op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		end else if (r < push_pct + pop_pct) begin
			op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
		end else begin
			case ($urandom_range(0, 2))
				0:       op = OP_READ_FRONT;
				1:       op = OP_READ_BACK;
				default: op = OP_READ_INDEX;
			endcase
		end
		pos = $urandom_range(0, 255);
		// mostly in range, edges favoured
		if (op == OP_READ_INDEX && held > 0 && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0:       pos = '0;
				1:       pos = POS_W'(held - 1);
				2:       pos = POS_W'(held);
				default: pos = POS_W'($urandom_range(0, held - 1));
			endcase
		end
		return pack_op(op, $urandom, pos);
	endfunction

	task automatic send(logic [IN_TDATA_W-1:0] beat);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		do @(negedge clk); while (!in_taken);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic run_segment(int beats, int push_pct, int pop_pct, int hold_at);
		for (int i = 0; i < beats; i++) begin
			if (i == hold_at) hold_req <= 1'b1;
			send(random_op(push_pct, pop_pct));
		end
	endtask

	initial begin
		sb          = new();
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		in_taken    = 1'b0;
		hold_req    = 1'b0;
		hold_left   = 0;
		quiet       = 0;
		tx_idle_pct = 20;
		rx_idle_pct = 45;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list, unused opcode, edge records, range limits
		send(pack_op(OP_POP_FRONT, $urandom, 8'd0));
		send(pack_op(OP_POP_BACK, $urandom, 8'd0));
		send(pack_op(OP_READ_FRONT, $urandom, 8'd0));
		send(pack_op(OP_READ_BACK, $urandom, 8'd0));
		send(pack_op(OP_READ_INDEX, $urandom, 8'd0));
		send(pack_op(OP_UNUSED, $urandom, 8'd255));
		send(pack_op(OP_PUSH_BACK, 32'hFFFF_FFFF, 8'd0));
		send(pack_op(OP_PUSH_FRONT, 32'h0000_0000, 8'd255));
		send(pack_op(OP_PUSH_BACK, 32'hA5A5_5A5A, 8'd0));
		send(pack_op(OP_PUSH_FRONT, 32'h5A5A_A5A5, 8'd0));
		send(pack_op(OP_UNUSED, 32'hFFFF_FFFF, 8'd0));
		send(pack_op(OP_READ_FRONT, $urandom, 8'd0));
		send(pack_op(OP_READ_BACK, $urandom, 8'd0));
		send(pack_op(OP_READ_INDEX, $urandom, 8'd0));
		send(pack_op(OP_READ_INDEX, $urandom, 8'd3));
		send(pack_op(OP_READ_INDEX, $urandom, 8'd4));
		send(pack_op(OP_READ_INDEX, $urandom, 8'd255));
		send(pack_op(OP_POP_FRONT, $urandom, 8'd0));
		send(pack_op(OP_POP_BACK, $urandom, 8'd0));
		send(pack_op(OP_READ_INDEX, $urandom, 8'd1));
		send(pack_op(OP_POP_FRONT, $urandom, 8'd0));
		send(pack_op(OP_POP_BACK, $urandom, 8'd0));
		send(pack_op(OP_READ_INDEX, $urandom, 8'd0));
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 20;
					rx_idle_pct <= 45;
				end
				1: begin
					tx_idle_pct = 45;
					rx_idle_pct <= 20;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			// fill past full, churn, then drain past empty
			run_segment(280, 95, 2, (p == 0) ? 150 : -1);
			run_segment(40, 35, 35, -1);
			run_segment(300, 2, 90, -1);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_bounded_double_ended_list: PASS");
		end else begin
			$display("tb_bounded_double_ended_list: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
hdl/bdel_pkg.sv
hdl/bdel_ram.sv
hdl/bdel_ctrl.sv
hdl/bounded_double_ended_list.sv
tb/tb_bounded_double_ended_list.sv
